// ----- sv/b64d_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package b64d_pkg;

  localparam int unsigned ResMax   = 3;
  localparam int unsigned BufDepth = 6;
  localparam int unsigned BufCntW  = $clog2(BufDepth + 1);
  localparam int unsigned ResCntW  = $clog2(ResMax + 1);

  localparam logic [7:0] CharPad   = 8'h3d;
  localparam logic [7:0] CharPlus  = 8'h2b;
  localparam logic [7:0] CharSlash = 8'h2f;
  localparam logic [7:0] SextetBad = 8'hff;

  localparam logic [1:0] FillTwo   = 2'd2;
  localparam logic [1:0] FillThree = 2'd3;

  typedef struct packed {
    logic [1:0]  group_fill;
    logic [17:0] held_sextets;
    logic        pad_seen;
  } state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       msg_end;
  } result_t;

  function automatic logic [7:0] sextet_of(input logic [7:0] c);
    logic [7:0] s;
    s = SextetBad;
    if (c >= 8'h41 && c <= 8'h5a) begin
      s = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      s = c - 8'd71;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s = c + 8'd4;
    end else if (c == CharPlus) begin
      s = 8'd62;
    end else if (c == CharSlash) begin
      s = 8'd63;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// ----- sv/base64_stream_decoder_core.sv -----
// streaming base64 decoder, standard alphabet
// slave side: one character per request on s_axis_tdata, s_axis_tlast marks
// the final character of a message
// master side: one decoded byte per request on m_axis_tdata, m_axis_tuser
// set when the byte carries data (clear for a bare end marker), m_axis_tlast
// on the final result of a message
// every fourth character yields three bytes; the first '=' stops decoding
// until the end of the message; a partial group of k characters at the end
// yields k-1 bytes, or a bare end marker if none is due
// a result is written into the result buffer when its character is taken
// and reaches the master side once the results ahead of it have left
// throughput: one character per cycle and one byte per cycle; a six-entry
// result buffer feeds the master side, and s_axis_tready drops while more
// than three results wait in it
// a stalled receiver only fills that buffer; no result is lost or repeated
// reset clears the group state and empties the buffer
`timescale 1ns / 1ps
`default_nettype none
module base64_stream_decoder_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,  // in_char[7:0]
  input  wire logic       s_axis_tlast,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,  // out_byte[7:0]
  output logic            m_axis_tuser,  // byte_valid
  output logic            m_axis_tlast
);

  b64d_pkg::state_t  state_q, state_d;
  b64d_pkg::result_t res [b64d_pkg::ResMax];
  b64d_pkg::result_t head;
  logic [b64d_pkg::ResCntW-1:0] res_cnt;
  logic accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  b64d_decode u_decode (
    .state_i     (state_q),
    .in_char_i   (s_axis_tdata),
    .char_last_i (s_axis_tlast),
    .state_o     (state_d),
    .res_o       (res),
    .res_cnt_o   (res_cnt)
  );

  b64d_outbuf u_outbuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (accept),
    .res_i     (res),
    .res_cnt_i (res_cnt),
    .space_o   (s_axis_tready),
    .tvalid_o  (m_axis_tvalid),
    .tready_i  (m_axis_tready),
    .head_o    (head)
  );

  assign m_axis_tdata = head.out_byte;
  assign m_axis_tuser = head.byte_valid;
  assign m_axis_tlast = head.msg_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ----- sv/b64d_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none
module b64d_decode (
  input  wire b64d_pkg::state_t  state_i,
  input  wire logic [7:0]        in_char_i,
  input  wire logic              char_last_i,
  output b64d_pkg::state_t       state_o,
  output b64d_pkg::result_t      res_o [b64d_pkg::ResMax],
  output logic [b64d_pkg::ResCntW-1:0] res_cnt_o
);

  localparam int unsigned ResCntW = b64d_pkg::ResCntW;

  always_comb begin
    b64d_pkg::state_t st;
    logic [7:0] s3;
    logic [5:0] s0, s1, s2;
    logic [7:0] b0, b1, b2;
    logic [b64d_pkg::ResCntW-1:0] n;

    st = state_i;
    n  = '0;
    b2 = '0;
    s3 = b64d_pkg::sextet_of(in_char_i);
    for (int i = 0; i < b64d_pkg::ResMax; i++) begin
      res_o[i] = '0;
    end

    if (!st.pad_seen) begin
      if (in_char_i == b64d_pkg::CharPad) begin
        st.pad_seen = 1'b1;
      end else if (st.group_fill == b64d_pkg::FillThree) begin
        s0 = st.held_sextets[17:12];
        s1 = st.held_sextets[11:6];
        s2 = st.held_sextets[5:0];
        b0 = {s0, s1[5:4]};
        b1 = {s1[3:0], s2[5:2]};
        b2 = {s2[1:0], 6'd0} + s3;
        res_o[0] = '{out_byte: b0, byte_valid: 1'b1, msg_end: 1'b0};
        res_o[1] = '{out_byte: b1, byte_valid: 1'b1, msg_end: 1'b0};
        res_o[2] = '{out_byte: b2, byte_valid: 1'b1, msg_end: char_last_i};
        n = ResCntW'(3);
        st.group_fill   = '0;
        st.held_sextets = '0;
      end else begin
        case (st.group_fill)
          2'd0:    st.held_sextets[17:12] = s3[5:0];
          2'd1:    st.held_sextets[11:6]  = s3[5:0];
          default: st.held_sextets[5:0]   = s3[5:0];
        endcase
        st.group_fill = st.group_fill + 2'd1;
      end
    end

    s0 = st.held_sextets[17:12];
    s1 = st.held_sextets[11:6];
    s2 = st.held_sextets[5:0];
    b0 = {s0, s1[5:4]};
    b1 = {s1[3:0], s2[5:2]};

    if (char_last_i) begin
      if (n == '0) begin
        case (st.group_fill)
          b64d_pkg::FillTwo: begin
            res_o[0] = '{out_byte: b0, byte_valid: 1'b1, msg_end: 1'b1};
            n = ResCntW'(1);
          end
          b64d_pkg::FillThree: begin
            res_o[0] = '{out_byte: b0, byte_valid: 1'b1, msg_end: 1'b0};
            res_o[1] = '{out_byte: b1, byte_valid: 1'b1, msg_end: 1'b1};
            n = ResCntW'(2);
          end
          default: begin
            res_o[0] = '{out_byte: 8'd0, byte_valid: 1'b0, msg_end: 1'b1};
            n = ResCntW'(1);
          end
        endcase
      end
      st = '0;
    end

    state_o   = st;
    res_cnt_o = n;
  end

endmodule
`default_nettype wire

// ----- sv/b64d_outbuf.sv -----
`timescale 1ns / 1ps
`default_nettype none
module b64d_outbuf (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire b64d_pkg::result_t             res_i [b64d_pkg::ResMax],
  input  wire logic [b64d_pkg::ResCntW-1:0]  res_cnt_i,
  output logic                               space_o,
  output logic                               tvalid_o,
  input  wire logic                          tready_i,
  output b64d_pkg::result_t                  head_o
);

  localparam int unsigned Depth = b64d_pkg::BufDepth;
  localparam int unsigned CntW  = b64d_pkg::BufCntW;

  b64d_pkg::result_t slot_q [Depth];
  b64d_pkg::result_t slot_d [Depth];
  logic [CntW-1:0]   cnt_q, cnt_d;

  logic pop;

  assign pop      = tvalid_o && tready_i;
  assign tvalid_o = (cnt_q != '0);
  assign space_o  = (cnt_q <= CntW'(Depth - b64d_pkg::ResMax));
  assign head_o   = slot_q[0];

  always_comb begin
    logic [CntW-1:0] base;
    base = cnt_q - CntW'(pop);
    for (int i = 0; i < Depth; i++) begin
      if (pop && i < Depth - 1) begin
        slot_d[i] = slot_q[i + 1];
      end else begin
        slot_d[i] = slot_q[i];
      end
      for (int j = 0; j < b64d_pkg::ResMax; j++) begin
        if (push_i && (CntW'(j) < CntW'(res_cnt_i)) && (CntW'(i) == base + CntW'(j))) begin
          slot_d[i] = res_i[j];
        end
      end
    end
    cnt_d = base + (push_i ? CntW'(res_cnt_i) : '0);
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned QuietLimit = 500;
  localparam int unsigned RandChars  = 445;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic [3:0] gap;
  } char_req_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tuser;
  logic       m_axis_tlast;

  char_req_t           pending_chars[$];
  b64d_pkg::result_t   due_bytes[$];
  logic [1:0]  fill = 2'd0;
  logic [17:0] held = 18'd0;
  logic        pad_hit = 1'b0;
  int unsigned src_idle_max = 10;
  int unsigned sink_idle_max = 10;
  int unsigned sink_wait = 0;
  int unsigned quiet_cycles = 0;
  int unsigned err_cnt = 0;
  int unsigned chars_in = 0;
  int unsigned msgs_in = 0;
  int unsigned bytes_out = 0;
  int unsigned markers_out = 0;

  base64_stream_decoder_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [7:0] sextet_value(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return c - "A";
    if (c >= "a" && c <= "z") return c - "a" + 8'd26;
    if (c >= "0" && c <= "9") return c - "0" + 8'd52;
    if (c == b64d_pkg::CharPlus) return 8'd62;
    if (c == b64d_pkg::CharSlash) return 8'd63;
    return b64d_pkg::SextetBad;
  endfunction

  function automatic logic [7:0] random_b64();
    int unsigned r;
    r = $urandom_range(0, 63);
    if (r < 26) return 8'("A" + r);
    if (r < 52) return 8'("a" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return (r == 62) ? b64d_pkg::CharPlus : b64d_pkg::CharSlash;
  endfunction

  task automatic queue_char(input logic [7:0] ch, input logic last);
    char_req_t r;
    r.ch = ch;
    r.last = last;
    r.gap = 4'($urandom_range(0, src_idle_max));
    pending_chars.push_back(r);
  endtask

  task automatic send_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) begin
      queue_char(s[i], last && (i == s.len() - 1));
    end
  endtask

  // expected bytes for one accepted character
  task automatic decode_char(input logic [7:0] c, input logic last);
    logic [7:0] sx;
    logic [7:0] b2;
    int unsigned n;
    n = 0;
    if (!pad_hit) begin
      if (c == b64d_pkg::CharPad) begin
        pad_hit = 1'b1;
      end else begin
        sx = sextet_value(c);
        if (fill == b64d_pkg::FillThree) begin
          // fourth sextet goes in at full width
          b2 = {held[1:0], 6'd0} + sx;
          due_bytes.push_back({held[17:12], held[11:10], 1'b1, 1'b0});
          due_bytes.push_back({held[9:6], held[5:2], 1'b1, 1'b0});
          due_bytes.push_back({b2, 1'b1, last});
          n = 3;
          fill = 2'd0;
          held = 18'd0;
        end else begin
          case (fill)
            2'd0: held[17:12] = sx[5:0];
            2'd1: held[11:6] = sx[5:0];
            default: held[5:0] = sx[5:0];
          endcase
          fill = fill + 2'd1;
        end
      end
    end
    if (last) begin
      if (n == 0) begin
        if (fill == b64d_pkg::FillTwo) begin
          due_bytes.push_back({held[17:12], held[11:10], 1'b1, 1'b1});
        end else if (fill == b64d_pkg::FillThree) begin
          due_bytes.push_back({held[17:12], held[11:10], 1'b1, 1'b0});
          due_bytes.push_back({held[9:6], held[5:2], 1'b1, 1'b1});
        end else begin
          due_bytes.push_back({8'h00, 1'b0, 1'b1});
        end
      end
      fill = 2'd0;
      held = 18'd0;
      pad_hit = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin : drive_proc
    logic present;
    present = s_axis_tvalid;
    if (!rst_ni) begin
      present = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_char(s_axis_tdata, s_axis_tlast);
        chars_in++;
        if (s_axis_tlast) msgs_in++;
        present = 1'b0;
      end
      if (!present && pending_chars.size() != 0) begin
        if (pending_chars[0].gap != 0) begin
          pending_chars[0].gap = pending_chars[0].gap - 4'd1;
        end else begin
          s_axis_tdata <= pending_chars[0].ch;
          s_axis_tlast <= pending_chars[0].last;
          void'(pending_chars.pop_front());
          present = 1'b1;
        end
      end
    end
    s_axis_tvalid <= present;
  end

  always @(posedge clk_i) begin : check_proc
    b64d_pkg::result_t seen;
    b64d_pkg::result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen = {m_axis_tdata, m_axis_tuser, m_axis_tlast};
        if (seen.byte_valid) bytes_out++;
        else markers_out++;
        if (due_bytes.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected byte, expected none, got data %02h valid %0b end %0b",
                   $time, seen.out_byte, seen.byte_valid, seen.msg_end);
        end else begin
          want = due_bytes.pop_front();
          if (seen.out_byte !== want.out_byte || seen.byte_valid !== want.byte_valid ||
              seen.msg_end !== want.msg_end) begin
            err_cnt++;
            $display("%0t: mismatch, expected data %02h valid %0b end %0b, got data %02h valid %0b end %0b",
                     $time, want.out_byte, want.byte_valid, want.msg_end,
                     seen.out_byte, seen.byte_valid, seen.msg_end);
          end
        end
        sink_wait = $urandom_range(0, sink_idle_max);
        // switch between stalling and streaming stretches now and then
        if ($urandom_range(0, 49) == 0) sink_idle_max = (sink_idle_max == 0) ? 10 : 0;
      end else if (sink_wait != 0) begin
        sink_wait--;
      end
      m_axis_tready <= (sink_wait == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("%0t: timeout, nothing moved for %0d cycles", $time, QuietLimit);
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [7:0] msg[$];
    int unsigned kind;
    int unsigned dn;
    int unsigned counted;

    // directed messages
    send_text("TWFu", 1'b1);
    send_text("TWE=", 1'b1);
    send_text("TQ==", 1'b1);
    send_text("/+9z", 1'b0);
    send_text("A", 1'b1);
    send_text("=", 1'b1);
    send_text("ab=Z", 1'b1);
    // characters outside the alphabet, the last one at full width
    queue_char(8'h00, 1'b0);
    queue_char(8'hff, 1'b0);
    queue_char(8'h80, 1'b0);
    queue_char(8'h7f, 1'b1);

    // random messages: mostly well formed, some noise and broken padding
    counted = 0;
    while (counted < RandChars) begin
      msg.delete();
      src_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        dn = $urandom_range(1, 14);
        repeat (dn) msg.push_back(random_b64());
        if (dn % 4 == 2) msg.push_back(b64d_pkg::CharPad);
        if (dn % 4 != 0 && dn % 4 != 1) msg.push_back(b64d_pkg::CharPad);
      end else if (kind < 17) begin
        repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(0, 6)) msg.push_back(random_b64());
        msg.push_back(b64d_pkg::CharPad);
        repeat ($urandom_range(0, 3)) msg.push_back(8'($urandom_range(0, 255)));
      end
      foreach (msg[i]) queue_char(msg[i], i == msg.size() - 1);
      counted += msg.size();
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_chars.size() != 0 || s_axis_tvalid || due_bytes.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (20) @(posedge clk_i);

    $display("sent %0d characters in %0d messages", chars_in, msgs_in);
    $display("received %0d decoded bytes and %0d bare end markers", bytes_out, markers_out);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
